FILE: hw/rtl/tspm_pkg.sv
// Shared types, constants and the arctangent table for the three-step phase core.
// No dependencies; every other file of the block imports this package.
package tspm_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int PHASE_BITS      = 16;
    localparam int ROTATION_STAGES = 16;

    localparam int FRAC_BITS     = 14;
    localparam int PHASE_FIELD_W = 16;
    localparam int MAG_BITS      = 8;

    // sqrt(3) in Q1.14 and its exact square
    localparam int         SQRT3_Q14 = 28378;
    localparam logic [29:0] SQRT3_SQ = 30'd805310884;

    localparam int XD_W   = PIXEL_BITS + 3;
    localparam int D_W    = PIXEL_BITS + 1;
    localparam int YQ_W   = D_W + 15;
    localparam int XD2_W  = 2 * (PIXEL_BITS + 1);
    localparam int D2_W   = 2 * PIXEL_BITS;
    localparam int PROD_W = D2_W + 30;
    localparam int TW     = 2 * PIXEL_BITS + 5;
    localparam int CW     = PIXEL_BITS + FRAC_BITS + 5;

    localparam int ROT_IDX_W = $clog2(ROTATION_STAGES);
    localparam int MAG_IDX_W = $clog2(MAG_BITS);

    // front stages, then one stage per rotation cell
    localparam int NSTG    = ROTATION_STAGES + 2;
    localparam int MAG_PAD = ROTATION_STAGES - MAG_BITS;

    localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [PIXEL_BITS-1:0] intensity_first;
        logic [PIXEL_BITS-1:0] intensity_second;
        logic [PIXEL_BITS-1:0] intensity_third;
    } tspm_in_t;

    typedef struct packed {
        logic [PHASE_FIELD_W-1:0] wrapped_phase;
        logic [MAG_BITS-1:0]      modulation_magnitude;
    } tspm_out_t;

    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic [PHASE_BITS-1:0] z;
        logic                  on_axis;
    } tspm_rot_t;

    typedef struct packed {
        logic [TW-1:0]       t;
        logic [MAG_BITS-1:0] m;
    } tspm_root_t;

    // Round the table entry to the phase resolution.
    function automatic logic [PHASE_BITS-1:0] stage_angle(input logic [ROT_IDX_W-1:0] idx);
        logic [32:0] sum;
        sum = {1'b0, ATAN_TURNS[idx]} + (33'd1 << (31 - PHASE_BITS));
        return PHASE_BITS'(sum >> (32 - PHASE_BITS));
    endfunction

endpackage

FILE: hw/rtl/three_step_phase_magnitude_core.sv
// Top level of the three-step phase and modulation core.
// Depends on tspm_pkg, tspm_front, tspm_rot_cell and tspm_root_cell.
//
// Usage: one beat on the s_ channel carries a pixel's three fringe intensities;
// one beat on the m_ channel returns its wrapped phase (65536 units per turn)
// and its rounded modulation, saturated at 255. Every input beat gives exactly
// one output beat, in order.
// Throughput: one beat per cycle when the output is not stalled, set by the row
// of rotation cells, each doing one step per cycle. The magnitude runs
// alongside in eight root-digit cells and a delay line.
// Stall: each stage holds only while the stage after it is full, so empty
// stages keep filling while a result waits on m_ready; s_ready falls once
// every stage holds a beat.
// Reset: aresetn (synchronous, active low) empties every stage; in-flight
// beats are dropped.
module three_step_phase_magnitude_core
    import tspm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tspm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tspm_out_t m_data
);

    logic [NSTG:0]       stage_en;
    logic [NSTG-1:0]     valid_reg, valid_next, valid_prev;
    logic                m_valid_reg, m_valid_next;
    tspm_out_t           m_data_reg;
    logic [MAG_BITS-1:0] mag_final;

    tspm_rot_t  rot_bus  [0:ROTATION_STAGES];
    tspm_root_t root_bus [0:MAG_BITS];

    // Advance a stage when it is empty or the stage after it advances.
    always_comb begin
        stage_en[NSTG] = !m_valid_reg || m_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_prev   = {valid_reg[NSTG-2:0], s_valid};
        valid_next   = (stage_en[NSTG-1:0] & valid_prev) | (~stage_en[NSTG-1:0] & valid_reg);
        m_valid_next = stage_en[NSTG] ? valid_reg[NSTG-1] : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    tspm_front u_front (
        .aclk     (aclk),
        .en       (stage_en[1:0]),
        .s_data   (s_data),
        .rot_out  (rot_bus[0]),
        .root_out (root_bus[0])
    );

    for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_rot
        tspm_rot_cell u_cell (
            .aclk      (aclk),
            .en        (stage_en[k+2]),
            .stage_idx (ROT_IDX_W'(k)),
            .cell_in   (rot_bus[k]),
            .cell_out  (rot_bus[k+1])
        );
    end

    // most significant magnitude bit first
    for (genvar j = 0; j < MAG_BITS; j++) begin : g_root
        tspm_root_cell u_cell (
            .aclk     (aclk),
            .en       (stage_en[j+2]),
            .bit_idx  (MAG_IDX_W'(MAG_BITS - 1 - j)),
            .cell_in  (root_bus[j]),
            .cell_out (root_bus[j+1])
        );
    end

    // Delay the magnitude to line up with the last rotation cell.
    if (MAG_PAD > 0) begin : g_pad
        logic [MAG_BITS-1:0] pad_reg [MAG_PAD];

        for (genvar p = 0; p < MAG_PAD; p++) begin : g_tap
            always_ff @(posedge aclk) begin
                if (stage_en[MAG_BITS+2+p]) begin
                    pad_reg[p] <= (p == 0) ? root_bus[MAG_BITS].m : pad_reg[(p == 0) ? 0 : p-1];
                end
            end
        end

        assign mag_final = pad_reg[MAG_PAD-1];
    end else begin : g_nopad
        assign mag_final = root_bus[MAG_BITS].m;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NSTG]) begin
            m_data_reg.wrapped_phase        <= PHASE_FIELD_W'(rot_bus[ROTATION_STAGES].z);
            m_data_reg.modulation_magnitude <= mag_final;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/tspm_front.sv
// Front stages: forms x, y and their squares, then the vector for rotation and the
// scaled squared magnitude for the root cells. Depends on tspm_pkg.
module tspm_front
    import tspm_pkg::*;
(
    input  logic       aclk,
    input  logic [1:0] en,
    input  tspm_in_t   s_data,
    output tspm_rot_t  rot_out,
    output tspm_root_t root_out
);

    logic signed [XD_W-1:0]   i1_s, i2_s, i3_s, xd_next, xd_reg;
    logic signed [D_W-1:0]    d_next, d_reg;
    logic signed [YQ_W-1:0]   yq_next, yq_reg;
    logic signed [2*XD_W-1:0] xsq;
    logic signed [2*D_W-1:0]  dsq;
    logic [XD2_W-1:0]         xd2_next, xd2_reg;
    logic [D2_W-1:0]          d2_next, d2_reg;

    logic signed [CW-1:0] xq, yq_ext;
    logic [PROD_W-1:0]    prod;
    tspm_rot_t            rot_next, rot_reg;
    tspm_root_t           root_next, root_reg;

    always_comb begin
        i1_s     = XD_W'(s_data.intensity_first);
        i2_s     = XD_W'(s_data.intensity_second);
        i3_s     = XD_W'(s_data.intensity_third);
        xd_next  = (i1_s <<< 1) - i2_s - i3_s;
        d_next   = D_W'(s_data.intensity_second) - D_W'(s_data.intensity_third);
        yq_next  = YQ_W'(d_next) * YQ_W'(SQRT3_Q14);
        xsq      = (2*XD_W)'(xd_next) * (2*XD_W)'(xd_next);
        dsq      = (2*D_W)'(d_next) * (2*D_W)'(d_next);
        xd2_next = xsq[XD2_W-1:0];
        d2_next  = dsq[D2_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            xd_reg  <= xd_next;
            d_reg   <= d_next;
            yq_reg  <= yq_next;
            xd2_reg <= xd2_next;
            d2_reg  <= d2_next;
        end
    end

    // Turn a left-half vector by a half turn so the rotations start with x >= 0.
    always_comb begin
        xq     = CW'(xd_reg) <<< FRAC_BITS;
        yq_ext = CW'(yq_reg);
        rot_next.x       = xd_reg[XD_W-1] ? -xq : xq;
        rot_next.y       = xd_reg[XD_W-1] ? -yq_ext : yq_ext;
        rot_next.z       = xd_reg[XD_W-1] ? PHASE_HALF : '0;
        rot_next.on_axis = (d_reg == '0);

        // (X^2 + Y^2) / 2^26 with X = xd * 2^14 and Y^2 = d^2 * 3 in Q.28
        prod        = PROD_W'(d2_reg) * PROD_W'(SQRT3_SQ);
        root_next.t = TW'({xd2_reg, 2'b00}) + TW'(prod >> (2*FRAC_BITS - 2));
        root_next.m = '0;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            rot_reg  <= rot_next;
            root_reg <= root_next;
        end
    end

    assign rot_out  = rot_reg;
    assign root_out = root_reg;

endmodule

FILE: hw/rtl/tspm_rot_cell.sv
// One vectoring rotation cell: turns the vector towards the x axis by atan(2^-i).
// Depends on tspm_pkg for the vector type and the angle table.
module tspm_rot_cell
    import tspm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [ROT_IDX_W-1:0] stage_idx,
    input  tspm_rot_t            cell_in,
    output tspm_rot_t            cell_out
);

    logic signed [CW-1:0]  x_in, y_in, dx, dy;
    logic [PHASE_BITS-1:0] angle;
    tspm_rot_t             rot_next, rot_reg;

    always_comb begin
        x_in     = cell_in.x;
        y_in     = cell_in.y;
        dx       = y_in >>> stage_idx;
        dy       = x_in >>> stage_idx;
        angle    = stage_angle(stage_idx);
        rot_next = cell_in;
        // hold vectors that lie on the x axis; their angle is already final
        if (!cell_in.on_axis) begin
            if (!y_in[CW-1] && (y_in != '0)) begin
                rot_next.x = x_in + dx;
                rot_next.y = y_in - dy;
                rot_next.z = cell_in.z + angle;
            end else begin
                rot_next.x = x_in - dx;
                rot_next.y = y_in + dy;
                rot_next.z = cell_in.z - angle;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign cell_out = rot_reg;

endmodule

FILE: hw/rtl/tspm_root_cell.sv
// One digit cell of the rounded square root: settles one bit of the magnitude.
// Depends on tspm_pkg for the root lane type.
module tspm_root_cell
    import tspm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [MAG_IDX_W-1:0] bit_idx,
    input  tspm_root_t           cell_in,
    output tspm_root_t           cell_out
);

    logic [MAG_BITS-1:0]     trial;
    logic [MAG_BITS:0]       odd;
    logic [2*MAG_BITS+1:0]   odd_sq;
    tspm_root_t              root_next, root_reg;

    // Keep the bit when t >= (2m - 1)^2: that is round(sqrt(t) / 2) >= m.
    always_comb begin
        trial     = cell_in.m | (MAG_BITS'(1) << bit_idx);
        odd       = {trial, 1'b0} - (MAG_BITS+1)'(1);
        odd_sq    = (2*MAG_BITS+2)'(odd) * (2*MAG_BITS+2)'(odd);
        root_next = cell_in;
        if (TW'(odd_sq) <= cell_in.t) begin
            root_next.m = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= root_next;
        end
    end

    assign cell_out = root_reg;

endmodule

FILE: hw/rtl/tspm_checker.sv
// Port-level checks for the three-step phase core, bound to the top level.
// Depends on tspm_pkg and three_step_phase_magnitude_core.
module tspm_checker
    import tspm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input tspm_out_t m_data
);

    // reset empties the output register
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // with the output free every stage can advance, so the input must be open
    a_ready_open : assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low while the output can drain");

    a_valid_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("m_valid dropped on a stalled beat");

    a_data_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("m_data changed on a stalled beat");

endmodule

bind three_step_phase_magnitude_core tspm_checker u_tspm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/three_step_phase_magnitude_core_tb.sv
// Self-checking testbench for three_step_phase_magnitude_core: directed pixels, then random ones,
// checked beat by beat against typed values or a CORDIC phase and exact-root magnitude predictor.
// Depends on tspm_pkg and the core RTL only.
`timescale 1ns / 100ps

module three_step_phase_magnitude_core_tb;
    import tspm_pkg::*;

    localparam int ACCEPT_TIMEOUT = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PIXELS  = 1830;
    localparam int CALM_PIXELS    = 200;
    localparam int MAX_REPORTS    = 40;
    localparam int N_DIRECTED     = 25;

    localparam longint      ROOT3_Q14    = 28378;
    localparam int          Q_SHIFT      = 14;
    localparam int          CORDIC_STEPS = 16;
    localparam logic [15:0] HALF_TURN    = 16'h8000;
    localparam logic [15:0] ZERO_TURN    = 16'h0000;

    // atan(2^-k) in 2^-32 turn
    localparam logic [31:0] ATAN_TURN [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    localparam int CORNER [0:5] = '{0, 1, 127, 128, 254, 255};

    typedef struct packed {
        tspm_in_t  px;
        logic      typed;
        tspm_out_t want;
    } stim_row_t;

    // I1, I2, I3, typed, phase, magnitude; untyped rows go through the predictor
    localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        {8'd0,   8'd0,   8'd0,   1'b1, ZERO_TURN, 8'd0},
        {8'd255, 8'd255, 8'd255, 1'b1, ZERO_TURN, 8'd0},
        {8'd77,  8'd77,  8'd77,  1'b1, ZERO_TURN, 8'd0},
        {8'd255, 8'd0,   8'd0,   1'b1, ZERO_TURN, 8'd255},
        {8'd0,   8'd255, 8'd255, 1'b1, HALF_TURN, 8'd255},
        {8'd100, 8'd0,   8'd0,   1'b1, ZERO_TURN, 8'd200},
        {8'd0,   8'd50,  8'd50,  1'b1, HALF_TURN, 8'd100},
        {8'd1,   8'd0,   8'd0,   1'b1, ZERO_TURN, 8'd2},
        {8'd0,   8'd1,   8'd1,   1'b1, HALF_TURN, 8'd2},
        {8'd128, 8'd0,   8'd0,   1'b1, ZERO_TURN, 8'd255},
        {8'd127, 8'd0,   8'd0,   1'b1, ZERO_TURN, 8'd254},
        {8'd0,   8'd255, 8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd0,   8'd0,   8'd255, 1'b0, ZERO_TURN, 8'd0},
        {8'd255, 8'd255, 8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd255, 8'd0,   8'd255, 1'b0, ZERO_TURN, 8'd0},
        {8'd1,   8'd1,   8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd0,   8'd0,   8'd1,   1'b0, ZERO_TURN, 8'd0},
        {8'd0,   8'd1,   8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd128, 8'd127, 8'd128, 1'b0, ZERO_TURN, 8'd0},
        {8'd128, 8'd255, 8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd127, 8'd255, 8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd85,  8'd170, 8'd0,   1'b0, ZERO_TURN, 8'd0},
        {8'd170, 8'd0,   8'd85,  1'b0, ZERO_TURN, 8'd0},
        {8'd170, 8'd85,  8'd85,  1'b0, ZERO_TURN, 8'd0},
        {8'd85,  8'd170, 8'd85,  1'b0, ZERO_TURN, 8'd0}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tspm_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    tspm_out_t m_data;

    tspm_out_t phase_mag_due [$];
    int        mismatches;
    int        quiet_cycles;
    bit        calm;

    three_step_phase_magnitude_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Wrapped phase by CORDIC vectoring, magnitude by exact integer root.
    function automatic tspm_out_t phase_and_modulation(input tspm_in_t px);
        longint          xq;
        longint          yq;
        longint          cx;
        longint          cy;
        longint          dx;
        longint          dy;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned mag;
        logic [31:0]     z;
        tspm_out_t       r;

        xq = (2 * longint'(px.intensity_first) - longint'(px.intensity_second)
              - longint'(px.intensity_third)) * (longint'(1) << Q_SHIFT);
        yq = (longint'(px.intensity_second) - longint'(px.intensity_third)) * ROOT3_Q14;

        sq    = longint'(xq * xq + yq * yq);
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > sq)
            probe >>= 2;
        while (probe != 0) begin
            if (sq >= root + probe) begin
                sq   -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        mag = (root + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
        if (mag > 255)
            mag = 255;

        z = 32'd0;
        if (yq == 0) begin
            // on the x axis: no rotation at all
            if (xq < 0)
                z = {16'd0, HALF_TURN};
        end else begin
            cx = xq;
            cy = yq;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z  = {16'd0, HALF_TURN};
            end
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                dx = cy >>> k;
                dy = cx >>> k;
                if (cy > 0) begin
                    cx += dx;
                    cy -= dy;
                    z  += (ATAN_TURN[k] + 32'h8000) >> 16;
                end else begin
                    cx -= dx;
                    cy += dy;
                    z  -= (ATAN_TURN[k] + 32'h8000) >> 16;
                end
            end
        end

        r.wrapped_phase        = z[15:0];
        r.modulation_magnitude = mag[7:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Present one pixel, optionally after an idle burst, and hold it until accepted.
    task automatic send_pixel(input tspm_in_t px, input logic typed, input tspm_out_t want,
                              input bit gaps_on);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        phase_mag_due.push_back(typed ? want : phase_and_modulation(px));
    endtask

    // Result side: stretches of ready mixed with stall bursts, none once calm.
    initial begin
        int span;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                span = $urandom_range(1, 30);
            end else begin
                m_ready <= 1'b0;
                span = $urandom_range(1, 10);
            end
            repeat (span) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        tspm_out_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (phase_mag_due.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_data.wrapped_phase, 0);
            end else begin
                want = phase_mag_due.pop_front();
                if (m_data.wrapped_phase !== want.wrapped_phase)
                    report_mismatch("wrapped_phase", m_data.wrapped_phase,
                                    want.wrapped_phase);
                if (m_data.modulation_magnitude !== want.modulation_magnitude)
                    report_mismatch("modulation_magnitude", m_data.modulation_magnitude,
                                    want.modulation_magnitude);
            end
        end
    end

    initial begin
        wait (quiet_cycles >= ACCEPT_TIMEOUT);
        $display("three_step_phase_magnitude_core_tb: done, errors");
        $finish;
    end

    initial begin
        tspm_in_t px;
        int       a;
        int       b;
        int       c;

        mismatches   = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++)
            send_pixel(DIRECTED_ROWS[n].px, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want,
                       1'b1);

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            a = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                4: c = b;
                5: begin
                    b = a;
                    c = a;
                end
                6: begin
                    // small differences around one level
                    b = a + $urandom_range(0, 6) - 3;
                    c = a + $urandom_range(0, 6) - 3;
                    b = (b < 0) ? 0 : ((b > 255) ? 255 : b);
                    c = (c < 0) ? 0 : ((c > 255) ? 255 : c);
                end
                7: begin
                    a = CORNER[$urandom_range(0, 5)];
                    b = CORNER[$urandom_range(0, 5)];
                    c = CORNER[$urandom_range(0, 5)];
                end
                8: begin
                    // x = 0: straight up or down
                    if ((b + c) % 2 != 0)
                        c = c ^ 1;
                    a = (b + c) / 2;
                end
                9: begin
                    a = 1 << $urandom_range(0, 7);
                    b = 255 - (1 << $urandom_range(0, 7));
                    c = $urandom_range(0, 1) ? 255 : 0;
                end
                default: ;
            endcase
            px.intensity_first  = 8'(a);
            px.intensity_second = 8'(b);
            px.intensity_third  = 8'(c);
            calm = (n >= RANDOM_PIXELS - CALM_PIXELS);
            send_pixel(px, 1'b0, '0, !calm && ((n / 48) % 4 != 0));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (phase_mag_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("three_step_phase_magnitude_core_tb: done, clean");
        else
            $display("three_step_phase_magnitude_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tspm_pkg.sv
hw/rtl/tspm_front.sv
hw/rtl/tspm_rot_cell.sv
hw/rtl/tspm_root_cell.sv
hw/rtl/three_step_phase_magnitude_core.sv
hw/rtl/tspm_checker.sv
sim/three_step_phase_magnitude_core_tb.sv
